// ===== rtl/sca_pkg.sv =====
// Shared constants and codes for the size-class block allocator.
package sca_pkg;
    localparam int NUM_CLASSES      = 8;
    localparam int BLOCKS_PER_CLASS = 256;
    localparam int CLASS_W   = $clog2(NUM_CLASSES);
    localparam int BLOCK_W   = $clog2(BLOCKS_PER_CLASS);
    localparam int LINK_W    = BLOCK_W + 1;
    localparam int CNT_W     = BLOCK_W + 1;
    localparam int TOTAL_W   = CLASS_W + 1;
    localparam int LINK_AW   = CLASS_W + BLOCK_W;
    localparam int SWEEP_W   = LINK_AW + 1;
    localparam int SIZE_W    = 21;
    localparam int FACTOR_W  = 12;
    localparam int HANDLE_W  = 12;
    localparam int GROW_W    = SIZE_W + FACTOR_W - 8;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_REBUILD = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;

    localparam logic [1:0] REG_MIN    = 2'd0;
    localparam logic [1:0] REG_MAX    = 2'd1;
    localparam logic [1:0] REG_FACTOR = 2'd2;
endpackage

// ===== rtl/sca_grow_unit.sv =====
// Shared multiply unit: next class size = max(floor(size*factor/256), size+1).
module sca_grow_unit
    import sca_pkg::*;
(
    input  logic                aclk,
    input  logic [SIZE_W-1:0]   size_in,
    input  logic [FACTOR_W-1:0] factor,
    output logic [GROW_W-1:0]   size_next_reg
);
    logic [SIZE_W+FACTOR_W-1:0] prod;
    logic [GROW_W-1:0]          grown;
    logic [GROW_W-1:0]          plus_one;
    logic [GROW_W-1:0]          size_next;

    always_comb begin
        prod      = {{FACTOR_W{1'b0}}, size_in} * {{SIZE_W{1'b0}}, factor};
        grown     = prod[SIZE_W+FACTOR_W-1:8];
        plus_one  = {{(GROW_W-SIZE_W){1'b0}}, size_in} + GROW_W'(1);
        size_next = (grown > plus_one) ? grown : plus_one;
    end

    always_ff @(posedge aclk) begin
        size_next_reg <= size_next;
    end
endmodule

// ===== rtl/sca_link_mem.sv =====
// Free-list link memory, one write port and one registered read port.
module sca_link_mem
    import sca_pkg::*;
(
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [LINK_AW-1:0] wr_addr,
    input  logic [LINK_W-1:0]  wr_data,
    input  logic [LINK_AW-1:0] rd_addr,
    output logic [LINK_W-1:0]  rd_data_reg
);
    logic [LINK_W-1:0] mem [NUM_CLASSES*BLOCKS_PER_CLASS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end
endmodule

// ===== rtl/size_class_block_allocator.sv =====
// Top level: sequencer, class tables and result register of the block allocator.
//  channel | ports                     | payload
//  in      | s_tvalid/s_tready         | s_tuser: func; s_tdata: need_size, handle
//  out     | m_tvalid/m_tready         | m_tuser: status; m_tdata: block_handle, granted_size
//  config  | cfg_we/cfg_addr/cfg_wdata | 0 min, 1 max, 2 growth factor
// Allocate scans the classes with one comparator, one class a cycle, up then down.
// Rebuild steps S_BUILD and S_BWAIT per class with the multiply unit, then sweeps the
// link memory one entry a cycle over all NUM_CLASSES*BLOCKS_PER_CLASS entries.
// Reset leaves no classes built.
// s_tready is low while an item is in work or a result waits on m_tready.
module size_class_block_allocator
    import sca_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [20:0] need_size, [32:21] handle, zero above
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [11:0] block_handle, [32:12] granted_size, zero above
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [20:0] cfg_wdata
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UP    = 4'd1;
    localparam logic [3:0] S_DOWN  = 4'd2;
    localparam logic [3:0] S_GRANT = 4'd3;
    localparam logic [3:0] S_FREE  = 4'd4;
    localparam logic [3:0] S_BUILD = 4'd5;
    localparam logic [3:0] S_BWAIT = 4'd6;
    localparam logic [3:0] S_SWEEP = 4'd7;

    logic [3:0]          state_reg, state_next;
    logic [SIZE_W-1:0]   min_reg, max_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [SIZE_W-1:0]   size_tab_reg [NUM_CLASSES];
    logic [SIZE_W-1:0]   size_tab_next [NUM_CLASSES];
    logic [LINK_W-1:0]   head_reg [NUM_CLASSES];
    logic [LINK_W-1:0]   head_next [NUM_CLASSES];
    logic [CNT_W-1:0]    count_reg [NUM_CLASSES];
    logic [CNT_W-1:0]    count_next [NUM_CLASSES];
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [TOTAL_W-1:0]  cls_reg, cls_next;
    logic [CLASS_W-1:0]  gcls_reg, gcls_next;
    logic [SIZE_W-1:0]   need_reg, need_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;
    logic [GROW_W-1:0]   sz_reg, sz_next;
    logic [SWEEP_W-1:0]  sweep_reg, sweep_next;
    logic                mv_reg, mv_next;
    logic [1:0]          mstat_reg, mstat_next;
    logic [HANDLE_W-1:0] mhnd_reg, mhnd_next;
    logic [SIZE_W-1:0]   msize_reg, msize_next;

    logic [GROW_W-1:0]   grow_q;
    logic                wr_en;
    logic [LINK_AW-1:0]  wr_addr, rd_addr;
    logic [LINK_W-1:0]   wr_data, rd_data;

    logic [CLASS_W-1:0]  scan_idx;
    logic                scan_ready;
    logic [HANDLE_W-1:0] hm1;
    logic [HANDLE_W-BLOCK_W-1:0] fcls;
    logic [CLASS_W-1:0]  fc;

    sca_grow_unit u_grow (
        .aclk          (aclk),
        .size_in       (sz_reg[SIZE_W-1:0]),
        .factor        (factor_reg),
        .size_next_reg (grow_q)
    );

    sca_link_mem u_link (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tuser  = mstat_reg;
    assign m_tdata  = {7'd0, msize_reg, mhnd_reg};

    always_comb begin
        scan_idx   = (state_reg == S_DOWN) ? CLASS_W'(cls_reg - TOTAL_W'(1))
                                           : cls_reg[CLASS_W-1:0];
        scan_ready = (count_reg[scan_idx] != '0) && !head_reg[scan_idx][BLOCK_W];
        hm1        = hnd_reg - HANDLE_W'(1);
        fcls       = hm1[HANDLE_W-1:BLOCK_W];
        fc         = fcls[CLASS_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        size_tab_next = size_tab_reg;
        head_next  = head_reg;
        count_next = count_reg;
        total_next = total_reg;
        cls_next   = cls_reg;
        gcls_next  = gcls_reg;
        need_next  = need_reg;
        hnd_next   = hnd_reg;
        sz_next    = sz_reg;
        sweep_next = sweep_reg;
        mv_next    = mv_reg;
        mstat_next = mstat_reg;
        mhnd_next  = mhnd_reg;
        msize_next = msize_reg;
        wr_en      = 1'b0;
        wr_addr    = sweep_reg[LINK_AW-1:0];
        wr_data    = LINK_W'(sweep_reg[BLOCK_W-1:0]) + LINK_W'(1);
        rd_addr    = {scan_idx, head_reg[scan_idx][BLOCK_W-1:0]};

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    need_next = s_tdata[20:0];
                    hnd_next  = s_tdata[32:21];
                    cls_next  = '0;
                    unique case (s_tuser)
                        FUNC_ALLOC:   state_next = S_UP;
                        FUNC_FREE:    state_next = S_FREE;
                        FUNC_REBUILD: begin
                            sz_next    = GROW_W'(min_reg);
                            state_next = S_BUILD;
                        end
                        default: begin
                            mv_next    = 1'b1;
                            mstat_next = ST_OK;
                            mhnd_next  = '0;
                            msize_next = '0;
                        end
                    endcase
                end
            end
            S_UP: begin
                if (cls_reg == total_reg) begin
                    state_next = S_DOWN;
                end else if (size_tab_reg[scan_idx] >= need_reg && scan_ready) begin
                    gcls_next  = scan_idx;
                    state_next = S_GRANT;
                end else begin
                    cls_next = cls_reg + TOTAL_W'(1);
                end
            end
            S_DOWN: begin
                if (cls_reg == '0) begin
                    mv_next    = 1'b1;
                    mstat_next = ST_NO_BLOCK;
                    mhnd_next  = '0;
                    msize_next = '0;
                    state_next = S_IDLE;
                end else if (size_tab_reg[scan_idx] < need_reg && scan_ready) begin
                    gcls_next  = scan_idx;
                    state_next = S_GRANT;
                end else begin
                    cls_next = cls_reg - TOTAL_W'(1);
                end
            end
            S_GRANT: begin
                // link of the popped block arrives from the memory now
                head_next[gcls_reg]  = rd_data;
                count_next[gcls_reg] = count_reg[gcls_reg] - CNT_W'(1);
                mv_next    = 1'b1;
                mstat_next = ST_OK;
                mhnd_next  = HANDLE_W'({gcls_reg, head_reg[gcls_reg][BLOCK_W-1:0]})
                             + HANDLE_W'(1);
                msize_next = size_tab_reg[gcls_reg];
                state_next = S_IDLE;
            end
            S_FREE: begin
                mv_next    = 1'b1;
                mhnd_next  = '0;
                msize_next = '0;
                state_next = S_IDLE;
                if (hnd_reg == '0 || (fcls >= HANDLE_W'(total_reg))
                        || count_reg[fc] >= CNT_W'(BLOCKS_PER_CLASS)) begin
                    mstat_next = ST_BAD;
                end else begin
                    mstat_next     = ST_OK;
                    wr_en          = 1'b1;
                    wr_addr        = {fc, hm1[BLOCK_W-1:0]};
                    wr_data        = head_reg[fc];
                    head_next[fc]  = LINK_W'(hm1[BLOCK_W-1:0]);
                    count_next[fc] = count_reg[fc] + CNT_W'(1);
                end
            end
            S_BUILD: begin
                if (sz_reg < GROW_W'(max_reg) && cls_reg < TOTAL_W'(NUM_CLASSES - 1)) begin
                    size_tab_next[cls_reg[CLASS_W-1:0]] = sz_reg[SIZE_W-1:0];
                    cls_next   = cls_reg + TOTAL_W'(1);
                    state_next = S_BWAIT;
                end else begin
                    for (int i = 0; i < NUM_CLASSES; i++) begin
                        if (TOTAL_W'(i) == cls_reg) begin
                            size_tab_next[i] = max_reg;
                        end else if (TOTAL_W'(i) > cls_reg) begin
                            size_tab_next[i] = '0;
                        end
                        head_next[i]  = '0;
                        count_next[i] = (TOTAL_W'(i) <= cls_reg)
                                        ? CNT_W'(BLOCKS_PER_CLASS) : '0;
                    end
                    total_next = cls_reg + TOTAL_W'(1);
                    sweep_next = '0;
                    state_next = S_SWEEP;
                end
            end
            S_BWAIT: begin
                sz_next    = grow_q;
                state_next = S_BUILD;
            end
            S_SWEEP: begin
                // link each block to the one after it
                wr_en      = 1'b1;
                sweep_next = sweep_reg + SWEEP_W'(1);
                if (sweep_reg == SWEEP_W'(NUM_CLASSES*BLOCKS_PER_CLASS - 1)) begin
                    mv_next    = 1'b1;
                    mstat_next = ST_OK;
                    mhnd_next  = '0;
                    msize_next = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mv_reg     <= 1'b0;
            total_reg  <= '0;
            min_reg    <= SIZE_W'(64);
            max_reg    <= SIZE_W'(1024);
            factor_reg <= FACTOR_W'(512);
            for (int i = 0; i < NUM_CLASSES; i++) begin
                size_tab_reg[i] <= '0;
                head_reg[i]     <= '0;
                count_reg[i]    <= '0;
            end
        end else begin
            state_reg    <= state_next;
            mv_reg       <= mv_next;
            total_reg    <= total_next;
            size_tab_reg <= size_tab_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_MIN:    min_reg    <= cfg_wdata;
                    REG_MAX:    max_reg    <= cfg_wdata;
                    REG_FACTOR: factor_reg <= cfg_wdata[FACTOR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg   <= cls_next;
        gcls_reg  <= gcls_next;
        need_reg  <= need_next;
        hnd_reg   <= hnd_next;
        sz_reg    <= sz_next;
        sweep_reg <= sweep_next;
        mstat_reg <= mstat_next;
        mhnd_reg  <= mhnd_next;
        msize_reg <= msize_next;
    end

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TOTAL_W'(NUM_CLASSES))
        else $error("class total out of range");

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("ready while busy");

    a_grant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GRANT) |=> (mv_reg && mstat_reg == ST_OK))
        else $error("grant gave no result");

    a_grant_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GRANT) |-> (count_reg[gcls_reg] != '0))
        else $error("grant from empty class");
endmodule

// ===== bench/size_class_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the size-class block allocator: directed items, then random traffic.
module size_class_block_allocator_tb;
    import sca_pkg::*;

    localparam int NBLK = NUM_CLASSES * BLOCKS_PER_CLASS;

    class alloc_scoreboard;
        logic [SIZE_W-1:0]   min_sz, max_sz;
        logic [FACTOR_W-1:0] factor;
        logic [SIZE_W-1:0]   cls_size [NUM_CLASSES];
        int unsigned         n_cls;
        int unsigned         link [NBLK];
        int unsigned         head [NUM_CLASSES];
        int unsigned         cnt [NUM_CLASSES];
        logic [1:0]          exp_status [$];
        logic [HANDLE_W-1:0] exp_handle [$];
        logic [SIZE_W-1:0]   exp_size [$];
        int                  errors;
        int unsigned         granted [$];

        function new();
            min_sz = 64;
            max_sz = 1024;
            factor = 512;
            n_cls = 0;
            errors = 0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                cls_size[c] = 0;
                head[c] = 0;
                cnt[c] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [20:0] v);
            if (idx == REG_MIN) min_sz = v;
            else if (idx == REG_MAX) max_sz = v;
            else if (idx == REG_FACTOR) factor = v[FACTOR_W-1:0];
        endfunction

        function void rebuild();
            logic [32:0] sz;
            logic [32:0] grown;
            n_cls = 0;
            sz = {12'd0, min_sz};
            while (sz < max_sz && n_cls < NUM_CLASSES - 1) begin
                cls_size[n_cls] = sz[SIZE_W-1:0];
                n_cls++;
                grown = (sz * factor) >> 8;
                sz = (grown > sz + 1) ? grown : sz + 1;
            end
            cls_size[n_cls] = max_sz;
            n_cls++;
            granted.delete();
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (c >= n_cls) cls_size[c] = 0;
                head[c] = 0;
                cnt[c] = (c < n_cls) ? BLOCKS_PER_CLASS : 0;
                if (c < n_cls)
                    for (int b = 0; b < BLOCKS_PER_CLASS; b++)
                        link[c*BLOCKS_PER_CLASS+b] = b + 1;
            end
        endfunction

        function bit ready(int c);
            return cnt[c] != 0 && head[c] < BLOCKS_PER_CLASS;
        endfunction

        // note one accepted word and queue its expected result
        function void note_input(logic [1:0] fn, logic [SIZE_W-1:0] need,
                                 logic [HANDLE_W-1:0] h);
            int pick;
            int unsigned b, cl, bl;
            logic [1:0] st;
            logic [HANDLE_W-1:0] oh;
            logic [SIZE_W-1:0] os;
            st = ST_OK; oh = 0; os = 0; pick = -1;
            if (fn == FUNC_ALLOC) begin
                for (int c = 0; c < n_cls && pick < 0; c++)
                    if (cls_size[c] >= need && ready(c)) pick = c;
                for (int c = n_cls - 1; c >= 0 && pick < 0; c--)
                    if (cls_size[c] < need && ready(c)) pick = c;
                if (pick < 0) st = ST_NO_BLOCK;
                else begin
                    b = head[pick];
                    head[pick] = link[pick*BLOCKS_PER_CLASS+b];
                    cnt[pick]--;
                    oh = HANDLE_W'(pick * BLOCKS_PER_CLASS + b + 1);
                    os = cls_size[pick];
                    granted = {granted, 32'(oh)};
                end
            end else if (fn == FUNC_FREE) begin
                if (h == 0) st = ST_BAD;
                else begin
                    cl = (h - 1) / BLOCKS_PER_CLASS;
                    bl = (h - 1) % BLOCKS_PER_CLASS;
                    if (cl >= n_cls || cnt[cl] >= BLOCKS_PER_CLASS) st = ST_BAD;
                    else begin
                        link[cl*BLOCKS_PER_CLASS+bl] = head[cl];
                        head[cl] = bl;
                        cnt[cl]++;
                    end
                end
            end else if (fn == FUNC_REBUILD) rebuild();
            exp_status = {exp_status, st};
            exp_handle = {exp_handle, oh};
            exp_size = {exp_size, os};
        endfunction

        function void check_result(logic [1:0] st, logic [39:0] d);
            if (exp_status.size() == 0) begin
                $display("%0t: unexpected result status %0d data %h", $realtime, st, d);
                errors++;
                return;
            end
            if (st !== exp_status[0] || d[11:0] !== exp_handle[0] ||
                d[32:12] !== exp_size[0] || d[39:33] !== 0) begin
                $display("%0t: mismatch expected st %0d h %0d sz %0d, actual st %0d h %0d sz %0d",
                         $realtime, exp_status[0], exp_handle[0], exp_size[0],
                         st, d[11:0], d[32:12]);
                errors++;
            end
            void'(exp_status.pop_front());
            void'(exp_handle.pop_front());
            void'(exp_size.pop_front());
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 0;
    logic [1:0]  cfg_addr = 0;
    logic [20:0] cfg_wdata = 0;
    bit          calm = 0;
    int          n_sent = 0;
    int          n_alloc_ok = 0, n_free_ok = 0, n_bad = 0;

    alloc_scoreboard sb = new();

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    size_class_block_allocator dut (.*);

    // result side: random stall bursts, none in the calm tail
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 13);
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (m_tuser == ST_OK && sb.exp_handle.size() && sb.exp_handle[0] != 0)
                    n_alloc_ok++;
                if (m_tuser == ST_BAD) n_bad++;
                sb.check_result(m_tuser, m_tdata);
            end
        end
    end

    // leave s_tvalid high after the accept; the caller drops it or sends again
    task automatic send(logic [1:0] fn, logic [SIZE_W-1:0] need, logic [HANDLE_W-1:0] h);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= fn;
        s_tdata <= {7'd0, h, need};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(fn, need, h);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.exp_status.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [20:0] v);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic setup(logic [20:0] mn, logic [20:0] mx, logic [11:0] fct);
        drain();
        write_reg(REG_MIN, mn);
        write_reg(REG_MAX, mx);
        write_reg(REG_FACTOR, fct);
        cfg_we <= 0;
        send(FUNC_REBUILD, SIZE_W'($urandom), HANDLE_W'($urandom));
    endtask

    task automatic random_item();
        int k;
        logic [HANDLE_W-1:0] h;
        k = $urandom_range(0, 99);
        if (k < 50) begin
            if ($urandom_range(0, 3) == 0)
                send(FUNC_ALLOC, SIZE_W'($urandom_range(0, 1048576)), HANDLE_W'($urandom));
            else send(FUNC_ALLOC, SIZE_W'($urandom_range(0, 4096)), HANDLE_W'($urandom));
        end else if (k < 90 && sb.granted.size() != 0) begin
            int i;
            i = $urandom_range(0, sb.granted.size() - 1);
            h = HANDLE_W'(sb.granted[i]);
            sb.granted.delete(i);
            send(FUNC_FREE, SIZE_W'($urandom), h);
        end else if (k < 96) begin
            // stray handles, with care not to break a list into unwritten links
            h = HANDLE_W'($urandom_range(0, 4095));
            if (h != 0 && (h - 1) / BLOCKS_PER_CLASS < sb.n_cls) h = 0;
            send(FUNC_FREE, SIZE_W'($urandom), h);
        end else if (k < 98) send(FUNC_REBUILD, SIZE_W'($urandom), HANDLE_W'($urandom));
        else send(2'd3, SIZE_W'($urandom), HANDLE_W'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: no classes yet, bad frees, unused func
        send(FUNC_ALLOC, 0, 0);
        send(FUNC_FREE, 0, 0);
        send(FUNC_FREE, 0, 1);
        send(FUNC_FREE, 21'h1FFFFF, 12'hFFF);
        send(2'd3, 21'h1FFFFF, 12'hFFF);
        send(FUNC_REBUILD, 0, 0);
        send(FUNC_ALLOC, 0, 0);
        send(FUNC_ALLOC, 1048576, 0);
        send(FUNC_ALLOC, 21'h1FFFFF, 0);
        send(FUNC_ALLOC, 100, 0);
        send(FUNC_FREE, 0, 1);   // return the first grant
        send(FUNC_FREE, 0, 2);   // class full
        send(FUNC_FREE, 0, 12'd2048);
        send(FUNC_FREE, 0, 12'd2049);
        setup(1048576, 9, 4095);      // minimum above maximum
        send(FUNC_ALLOC, 10, 0);
        send(FUNC_FREE, 0, 257);
        setup(9, 1048576, 256);       // factor of one: size+1 steps
        send(FUNC_ALLOC, 12, 0);
        send(FUNC_ALLOC, 1048576, 0);
        setup(9, 1048576, 4095);
        send(FUNC_ALLOC, 500000, 0);
        // exhaust both classes to reach the no-block case
        setup(100, 101, 300);
        for (int i = 0; i < 2 * BLOCKS_PER_CLASS + 2; i++) send(FUNC_ALLOC, 50, 0);
        // double free links a block to itself
        drain();
        send(FUNC_FREE, 0, 5);
        send(FUNC_FREE, 0, 5);
        send(FUNC_ALLOC, 50, 0);
        send(FUNC_ALLOC, 50, 0);
        send(FUNC_ALLOC, 50, 0);
        // random phases across several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: setup(64, 1024, 512);
                1: setup(9, 200, 300);
                2: setup(SIZE_W'($urandom_range(9, 5000)), SIZE_W'($urandom_range(9, 1048576)),
                         FACTOR_W'($urandom_range(256, 4095)));
                3: setup(SIZE_W'($urandom_range(9, 1048576)),
                         SIZE_W'($urandom_range(9, 1048576)),
                         FACTOR_W'($urandom_range(0, 4095)));
                4: setup(1000, 1048576, 4095);
                default: setup(SIZE_W'($urandom_range(9, 100)),
                               SIZE_W'($urandom_range(100, 3000)),
                               FACTOR_W'($urandom_range(260, 700)));
            endcase
            for (int i = 0; i < 84; i++) begin
                if (ph == 5 && i == 55) calm = 1;
                random_item();
            end
        end
        s_tvalid <= 0;
        while (sb.exp_status.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d words over directed and random pool settings; %0d grants, %0d invalid frees seen.",
                 n_sent, n_alloc_ok, n_bad);
        if (sb.errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #300ms;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/sca_pkg.sv
rtl/sca_grow_unit.sv
rtl/sca_link_mem.sv
rtl/size_class_block_allocator.sv
bench/size_class_block_allocator_tb.sv
